FILE: rtl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam logic [7:0]  CHAR_PAD     = 8'h3D;
    localparam logic [15:0] CAPACITY_RST = 16'd512;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_BAD_LENGTH      = 3'd1,
        ST_PAD_LONG        = 3'd2,
        ST_CAPACITY        = 3'd3,
        ST_BAD_FULL_GROUP  = 3'd4,
        ST_BAD_REMAINDER   = 3'd5,
        ST_BAD_FINAL_GROUP = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_input;
        t_status    status;
    } t_result;

    // bits held in the buffer after each group position
    function automatic logic [2:0] left_after(input logic [2:0] pos);
        logic [2:0] r;
        case (pos)
            3'd0: r = 3'd0;
            3'd1: r = 3'd5;
            3'd2: r = 3'd2;
            3'd3: r = 3'd7;
            3'd4: r = 3'd4;
            3'd5: r = 3'd1;
            3'd6: r = 3'd6;
            3'd7: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/b32d_map.sv
// ----------------------------------------------------------------------------
// b32d_map
// Alphabet lookup: A-Z and 2-7 to a 5-bit value, anything else flagged bad.
// ----------------------------------------------------------------------------
module b32d_map (
    input  logic [7:0] i_char,
    output logic [4:0] o_value,
    output logic       o_bad
);

    always_comb begin
        o_value = 5'd0;
        o_bad   = 1'b0;
        if (i_char >= 8'h41 && i_char <= 8'h5A) begin
            o_value = 5'(i_char - 8'h41);
        end else if (i_char >= 8'h32 && i_char <= 8'h37) begin
            o_value = 5'(i_char - 8'h32 + 8'd26);
        end else begin
            o_bad = 1'b1;
        end
    end

endmodule

FILE: rtl/b32d_core.sv
// ----------------------------------------------------------------------------
// b32d_core
// Stream state and the per-character step: bit buffer, group tracking,
// counters and the end-of-string status.
// ----------------------------------------------------------------------------
module b32d_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    input  logic [15:0]       i_capacity,
    output b32d_pkg::t_result o_result
);

    import b32d_pkg::*;

    localparam int FIVE_W = COUNT_WIDTH + 3;
    localparam int CMP_W  = (FIVE_W > 20) ? FIVE_W : 20;

    logic [6:0]             r_buf,       n_buf;
    logic [2:0]             r_gpos,      n_gpos;
    logic [2:0]             r_tlen,      n_tlen;
    logic                   r_pad_seen,  n_pad_seen;
    logic [3:0]             r_pad_cnt,   n_pad_cnt;
    logic [COUNT_WIDTH-1:0] r_cnt,       n_cnt;
    logic [FIVE_W-1:0]      r_five,      n_five;
    logic                   r_bad_early, n_bad_early;
    logic                   r_bad_cur,   n_bad_cur;

    logic [4:0]  map_val;
    logic        map_bad;
    logic [3:0]  nbits;
    logic [2:0]  rest;
    logic [11:0] acc;
    logic [19:0] cap_lim;
    logic        over_cap;
    t_result     res;

    b32d_map u_map (
        .i_char  (i_char),
        .o_value (map_val),
        .o_bad   (map_bad)
    );

    always_comb begin
        n_buf       = r_buf;
        n_gpos      = r_gpos;
        n_tlen      = r_tlen + 3'd1;
        n_pad_seen  = r_pad_seen | (i_char == CHAR_PAD);
        n_pad_cnt   = r_pad_cnt;
        n_cnt       = r_cnt;
        n_five      = r_five;
        n_bad_early = r_bad_early;
        n_bad_cur   = r_bad_cur;
        nbits       = {1'b0, left_after(r_gpos)} + 4'd5;
        rest        = 3'(nbits - 4'd8);
        acc         = {r_buf, map_val};
        res         = '{data_byte: 8'd0, byte_valid: 1'b0,
                        end_of_input: i_last, status: ST_OK};

        if (n_pad_seen) begin
            if (r_pad_cnt != 4'd8) begin
                n_pad_cnt = r_pad_cnt + 4'd1;
            end
        end else begin
            n_bad_cur = r_bad_cur | map_bad;
            if (nbits >= 4'd8) begin
                res.data_byte  = 8'(acc >> rest);
                res.byte_valid = 1'b1;
                n_buf          = 7'(acc & ((12'd1 << rest) - 12'd1));
            end else begin
                n_buf = acc[6:0];
            end
            n_gpos = r_gpos + 3'd1;
            if (n_gpos == 3'd0) begin
                n_bad_early = r_bad_early | n_bad_cur;
                n_bad_cur   = 1'b0;
            end
            if (r_cnt != {COUNT_WIDTH{1'b1}}) begin
                n_cnt  = r_cnt + 1'b1;
                n_five = r_five + FIVE_W'(5);
            end
        end

        // ceil(5n/8) > cap + 1  <=>  5n >= 8*(cap + 1) + 1
        cap_lim  = {17'(i_capacity) + 17'd1, 3'b001};
        over_cap = CMP_W'(n_five) >= CMP_W'(cap_lim);

        if (i_last) begin
            if (n_tlen != 3'd0) begin
                res.status = ST_BAD_LENGTH;
            end else if (n_pad_cnt >= 4'd8) begin
                res.status = ST_PAD_LONG;
            end else if (over_cap) begin
                res.status = ST_CAPACITY;
            end else if (n_bad_early) begin
                res.status = ST_BAD_FULL_GROUP;
            end else if (n_gpos == 3'd1 || n_gpos == 3'd3 || n_gpos == 3'd6) begin
                res.status = ST_BAD_REMAINDER;
            end else if (n_bad_cur) begin
                res.status = ST_BAD_FINAL_GROUP;
            end
            n_buf       = '0;
            n_gpos      = '0;
            n_tlen      = '0;
            n_pad_seen  = 1'b0;
            n_pad_cnt   = '0;
            n_cnt       = '0;
            n_five      = '0;
            n_bad_early = 1'b0;
            n_bad_cur   = 1'b0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_gpos      <= '0;
            r_tlen      <= '0;
            r_pad_seen  <= 1'b0;
            r_pad_cnt   <= '0;
            r_cnt       <= '0;
            r_five      <= '0;
            r_bad_early <= 1'b0;
            r_bad_cur   <= 1'b0;
        end else if (i_step) begin
            r_buf       <= n_buf;
            r_gpos      <= n_gpos;
            r_tlen      <= n_tlen;
            r_pad_seen  <= n_pad_seen;
            r_pad_cnt   <= n_pad_cnt;
            r_cnt       <= n_cnt;
            r_five      <= n_five;
            r_bad_early <= n_bad_early;
            r_bad_cur   <= n_bad_cur;
        end
    end

endmodule

FILE: rtl/base32_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base32_stream_decoder_top
// RFC 4648 base32 decoder, one character in and one result out per transfer.
// ----------------------------------------------------------------------------
// Takes one character per clock while the output is not stalled and returns
// one result per character: the input register holds the character, then
// the alphabet lookup, bit buffer step and status compare feed the result
// register. The result for a character marked tlast carries the status in
// tuser and leaves the decoder clear for the next string at once.
// The capacity register may be written only while no character is in flight.
// ----------------------------------------------------------------------------
module base32_stream_decoder_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic        m_axis_tlast
);

    import b32d_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_cap;
    logic        adv;
    t_result     core_res;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    b32d_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .i_capacity (r_cap),
        .o_result   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAPACITY_RST;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data_byte;
    assign m_axis_tuser  = {r_out.status, r_out.byte_valid};
    assign m_axis_tlast  = r_out.end_of_input;

endmodule

FILE: rtl/b32d_checker.sv
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks for the base32 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[3:1] == 3'd0)
        else $error("status outside last transfer");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("data byte without byte_valid");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind base32_stream_decoder_top b32d_checker u_b32d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/base32_stream_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// base32_stream_decoder_top_tb
// Self-checking testbench for the base32 stream decoder.
// ----------------------------------------------------------------------------
// Feeds strings one character per transfer, with random gaps on the input
// and random back-pressure on the output. A directed table covers alphabet
// and byte extremes, invalid characters and padding. It is followed by random
// strings: mostly well-formed base32 with random content, the rest noise,
// bad lengths, long padding, bad remainders and bad characters. The capacity
// register is rewritten between phases. Every result is compared field by
// field with its typed table row or else with an in-order decoder model.
// ----------------------------------------------------------------------------
module base32_stream_decoder_top_tb;

    import b32d_pkg::*;

    localparam int          LATENCY      = 2;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          PHASE_ITEMS  = 330;
    localparam int          MAX_PRINTS   = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [25] = '{
        '{8'h41,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_LENGTH}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h37,    1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, ST_OK}},
        '{8'h00,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h5A,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h32,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h7F,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h41,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h41,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h41,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'hFF,    1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ST_BAD_FULL_GROUP}},
        '{8'h41,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{8'h21,    1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
        '{CHAR_PAD, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_FINAL_GROUP}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] data_byte
    logic [3:0]  m_axis_tuser;            // [0] byte_valid, [3:1] status
    logic        m_axis_tlast;

    // decoder model state
    logic [15:0] cap_reg;
    logic [11:0] buf_bits;
    logic [2:0]  grp_pos;
    logic [2:0]  len_mod8;
    logic        pad_on;
    logic [15:0] pad_cnt;
    logic [15:0] data_cnt;
    logic        bad_prev;
    logic        bad_cur;

    t_result     result_q [$];
    logic [7:0]  text_q [$];
    int          errors       = 0;
    int          results_seen = 0;
    int          sent_items   = 0;
    int          stall_cycles = 0;
    int          out_hold     = 0;
    bit          gaps_on      = 1'b1;

    base32_stream_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h32 && c <= 8'h37);
    endfunction

    function automatic logic [7:0] alpha_char(input int idx);
        return (idx < 26) ? 8'(8'h41 + idx) : 8'(8'h32 + idx - 26);
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            return 8'h00;
        end
        do c = 8'($urandom_range(0, 255)); while (is_alpha(c) || c == CHAR_PAD);
        return c;
    endfunction

    function automatic void clear_decode();
        buf_bits = '0;
        grp_pos  = '0;
        len_mod8 = '0;
        pad_on   = 1'b0;
        pad_cnt  = '0;
        data_cnt = '0;
        bad_prev = 1'b0;
        bad_cur  = 1'b0;
    endfunction

    function automatic t_result decode_char(input logic [7:0] c, input logic last);
        t_result     r;
        logic [4:0]  v;
        logic [11:0] acc;
        int          held;
        int          rest;
        int unsigned need;
        r = '{8'h00, 1'b0, last, ST_OK};
        len_mod8 = len_mod8 + 3'd1;
        if (c == CHAR_PAD) begin
            pad_on = 1'b1;
        end
        if (pad_on) begin
            if (pad_cnt != 16'hFFFF) pad_cnt = pad_cnt + 16'd1;
        end else begin
            v = 5'd0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = 5'(c - 8'h41);
            end else if (c >= 8'h32 && c <= 8'h37) begin
                v = 5'(c - 8'h32 + 8'd26);
            end else begin
                bad_cur = 1'b1;
            end
            held = ((int'(grp_pos) * 5) % 8) + 5;
            acc  = {buf_bits[6:0], v};
            if (held >= 8) begin
                rest         = held - 8;
                r.data_byte  = 8'(acc >> rest);
                r.byte_valid = 1'b1;
                buf_bits     = acc & ((12'd1 << rest) - 12'd1);
            end else begin
                buf_bits = acc;
            end
            grp_pos = grp_pos + 3'd1;
            if (grp_pos == 3'd0) begin
                bad_prev = bad_prev | bad_cur;
                bad_cur  = 1'b0;
            end
            if (data_cnt != 16'hFFFF) data_cnt = data_cnt + 16'd1;
        end
        if (last) begin
            need = (32'(data_cnt) * 5 + 7) / 8;
            if (len_mod8 != 3'd0)                              r.status = ST_BAD_LENGTH;
            else if (pad_cnt >= 16'd8)                         r.status = ST_PAD_LONG;
            else if (32'(cap_reg) + 1 < need)                  r.status = ST_CAPACITY;
            else if (bad_prev)                                 r.status = ST_BAD_FULL_GROUP;
            else if (grp_pos == 3'd1 || grp_pos == 3'd3 || grp_pos == 3'd6)
                                                               r.status = ST_BAD_REMAINDER;
            else if (bad_cur)                                  r.status = ST_BAD_FINAL_GROUP;
            clear_decode();
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTS) begin
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        end
        errors++;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last,
                             input logic typed, input t_result want);
        int      gap;
        t_result pred;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = decode_char(ch, last);
        result_q.push_back(typed ? want : pred);
        sent_items++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            push_char(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_reg = value;
    endtask

    task automatic make_random_string();
        int kind;
        int dlen;
        int npad;
        kind = $urandom_range(0, 99);
        text_q.delete();
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind >= 88 && kind < 94) begin
            case ($urandom_range(0, 2))
                0:       dlen = 1;
                1:       dlen = 3;
                default: dlen = 6;
            endcase
            dlen += 8 * $urandom_range(0, 2);
        end else begin
            dlen = $urandom_range(1, 24);
            if (dlen % 8 == 1 || dlen % 8 == 3 || dlen % 8 == 6) dlen++;
        end
        npad = (8 - dlen % 8) % 8;
        repeat (dlen) text_q.push_back(alpha_char($urandom_range(0, 31)));
        repeat (npad) text_q.push_back(CHAR_PAD);
        if (kind >= 70 && kind < 76) begin
            text_q[$urandom_range(0, dlen - 1)] = bad_char();
        end else if (kind >= 76 && kind < 82) begin
            if ($urandom_range(0, 1) == 1 || text_q.size() < 2) begin
                text_q.push_back(alpha_char($urandom_range(0, 31)));
            end else begin
                void'(text_q.pop_back());
            end
        end else if (kind >= 82 && kind < 88) begin
            repeat (8 * $urandom_range(1, 2)) text_q.push_back(CHAR_PAD);
        end else if (kind >= 94) begin
            for (int i = dlen + 1; i < text_q.size(); i++) begin
                text_q[i] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1) == 1) text_q[$urandom_range(0, dlen - 1)] = bad_char();
        end
    endtask

    task automatic run_strings(input int n);
        int stop;
        stop = sent_items + n;
        while (sent_items < stop) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 39) == 0) wait_drained();
            make_random_string();
            send_text();
        end
    endtask

    // output side: check each transfer, then draw the next stall
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    report_error("result with no character pending");
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tdata !== want.data_byte)
                        report_error($sformatf("data_byte %02h, want %02h",
                                               m_axis_tdata, want.data_byte));
                    if (m_axis_tuser[0] !== want.byte_valid)
                        report_error($sformatf("byte_valid %b, want %b",
                                               m_axis_tuser[0], want.byte_valid));
                    if (m_axis_tlast !== want.end_of_input)
                        report_error($sformatf("end_of_input %b, want %b",
                                               m_axis_tlast, want.end_of_input));
                    if (m_axis_tuser[3:1] !== want.status)
                        report_error($sformatf("status %0d, want %0d",
                                               m_axis_tuser[3:1], want.status));
                end
                out_hold = gaps_on ? $urandom_range(0, 15) : 0;
            end
            if (out_hold > 0) begin
                m_axis_tready <= 1'b0;
                out_hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL base32_stream_decoder_top");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [15:0] caps [4];
        cap_reg = CAPACITY_RST;
        clear_decode();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            push_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
        end

        caps = '{16'h0000, 16'hFFFF, 16'($urandom_range(1, 6)), 16'($urandom_range(0, 65535))};
        run_strings(PHASE_ITEMS);
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_capacity(caps[p]);
            run_strings(PHASE_ITEMS);
        end

        wait_drained();
        if (errors == 0) begin
            $display("PASS base32_stream_decoder_top");
        end else begin
            $display("FAIL base32_stream_decoder_top");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/b32d_pkg.sv
rtl/b32d_map.sv
rtl/b32d_core.sv
rtl/base32_stream_decoder_top.sv
rtl/b32d_checker.sv
tb/base32_stream_decoder_top_tb.sv
